FILE: design/aescfb_pkg.sv
// aes-128 cfb encryption: shared types, register codes and round functions
// no dependencies; imported by every module of the block

package aescfb_pkg;

    // configuration register codes
    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_IV_HIGH  = 2'd2,
        CFG_IV_LOW   = 2'd3
    } cfg_reg_e;

    // plaintext beat
    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        restart;
    } plain_beat_t;

    // ciphertext beat
    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_beat_t;

    localparam int unsigned ROUNDS = 10;

    // forward substitution box
    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i of a 128-bit block, byte 0 at the top
    function automatic logic [7:0] get_byte(input logic [127:0] blk, input int unsigned i);
        return blk[127 - 8 * i -: 8];
    endfunction

    // multiply by x in the aes field
    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // sub bytes and shift rows together
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (c * 4 + r) -: 8] =
                    SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

    // mix columns
    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   all;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0  = get_byte(s, c * 4);
            a1  = get_byte(s, c * 4 + 1);
            a2  = get_byte(s, c * 4 + 2);
            a3  = get_byte(s, c * 4 + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (c * 4)     -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
            t[127 - 8 * (c * 4 + 1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
            t[127 - 8 * (c * 4 + 2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
            t[127 - 8 * (c * 4 + 3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        return t;
    endfunction

    // next round key from the current one
    function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                    input logic [7:0]   rc);
        logic [31:0]  w [0:3];
        logic [31:0]  t;
        t = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
             SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
        w[0] = rk[127:96] ^ t;
        w[1] = rk[95:64]  ^ w[0];
        w[2] = rk[63:32]  ^ w[1];
        w[3] = rk[31:0]   ^ w[2];
        return {w[0], w[1], w[2], w[3]};
    endfunction

endpackage

FILE: design/aescfb_round.sv
// aes-128 cfb encryption: one cipher round with its key schedule step
// depends on aescfb_pkg

module aescfb_round (
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    input  logic [7:0]   rcon,
    input  logic         skip_mix,
    output logic [127:0] state_out,
    output logic [127:0] key_out
);
    import aescfb_pkg::*;

    logic [127:0] shifted;
    logic [127:0] mixed;

    // state path
    assign shifted = sub_shift(state_in);
    assign mixed   = skip_mix ? shifted : mix(shifted);

    // key path and round key addition
    assign key_out   = next_round_key(key_in, rcon);
    assign state_out = mixed ^ key_out;

endmodule

FILE: design/aescfb_cipher.sv
// aes-128 cfb encryption: ten unrolled rounds giving the keystream block
// depends on aescfb_pkg and aescfb_round

module aescfb_cipher (
    input  logic [127:0] block_in,
    input  logic [127:0] key,
    output logic [127:0] block_out
);
    import aescfb_pkg::*;

    logic [127:0] state_chain [0:ROUNDS];
    logic [127:0] key_chain   [0:ROUNDS];
    logic [7:0]   rc_chain    [0:ROUNDS];

    // initial key addition
    assign state_chain[0] = block_in ^ key;
    assign key_chain[0]   = key;
    assign rc_chain[0]    = 8'h01;

    // round chain, last round without column mixing
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        assign rc_chain[g + 1] = gf_double(rc_chain[g]);

        aescfb_round u_round (
            .state_in  (state_chain[g]),
            .key_in    (key_chain[g]),
            .rcon      (rc_chain[g]),
            .skip_mix  (g == ROUNDS - 1),
            .state_out (state_chain[g + 1]),
            .key_out   (key_chain[g + 1])
        );
    end

    assign block_out = state_chain[ROUNDS];

endmodule

FILE: design/aes128_cfb_encrypt_core.sv
// aes-128 cfb encryption core: registers, handshakes and feedback
// depends on aescfb_pkg and aescfb_cipher
//
//  channel  signals                               direction  beat
//  pt       pt_valid pt_ready pt_beat             in         plaintext block, restart
//  ct       ct_valid ct_ready ct_beat             out        ciphertext block
//  cfg      cfg_valid cfg_ready cfg_index cfg_value in       key / iv half, 64 bits
//
// an accepted block is held in the input register until the output register is
// free or being read; the ten-round cipher then moves it into the output
// register, which offers its ciphertext. one block per cycle sustained with
// ct_ready high; the feedback loop through the unrolled rounds sets the clock.
// reset clears key, iv, feedback and both valid flags.
// a stalled output holds its beat while the input register still takes one more.

module aes128_cfb_encrypt_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pt_valid,
    output logic                       pt_ready,
    input  aescfb_pkg::plain_beat_t    pt_beat,
    output logic                       ct_valid,
    input  logic                       ct_ready,
    output aescfb_pkg::cipher_beat_t   ct_beat,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [63:0]                cfg_value
);
    import aescfb_pkg::*;

    plain_beat_t  in_reg;
    logic         in_valid_reg;
    cipher_beat_t out_reg;
    logic         out_valid_reg;
    logic [127:0] fb_reg;
    logic [127:0] key_reg;
    logic [127:0] iv_reg;

    logic         advance;
    logic [127:0] fb_sel;
    logic [127:0] keystream;
    logic [127:0] cipher_next;

    // handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || ct_ready);
    assign pt_ready  = !in_valid_reg || advance;
    assign ct_valid  = out_valid_reg;
    assign ct_beat   = out_reg;
    assign cfg_ready = 1'b1;

    // feedback choice and keystream
    assign fb_sel = in_reg.restart ? iv_reg : fb_reg;

    aescfb_cipher u_cipher (
        .block_in  (fb_sel),
        .key       (key_reg),
        .block_out (keystream)
    );

    assign cipher_next = keystream ^ {in_reg.plain_high, in_reg.plain_low};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_KEY_HIGH: key_reg[127:64] <= cfg_value;
                CFG_KEY_LOW:  key_reg[63:0]   <= cfg_value;
                CFG_IV_HIGH:  iv_reg[127:64]  <= cfg_value;
                CFG_IV_LOW:   iv_reg[63:0]    <= cfg_value;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pt_ready)
        begin
            in_valid_reg <= pt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_valid && pt_ready)
        begin
            in_reg <= pt_beat;
        end
    end

    // feedback and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fb_reg        <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                fb_reg        <= cipher_next;
            end
            else if (ct_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.cipher_high <= cipher_next[127:64];
            out_reg.cipher_low  <= cipher_next[63:0];
        end
    end

endmodule
